[design/rccsg_pkg.sv]
// shared types and constants for the raycast column span generator
// request and result structs, field widths, region and command codes
// no dependencies
package rccsg_pkg;

    localparam int SCREEN_ROWS  = 200;
    localparam int INTERP       = 4;
    localparam int TEX_SIZE     = 64;
    localparam int BLOCK_PIXELS = 64;

    localparam int DIST_W  = 24;
    localparam int RAY_W   = 10;
    localparam int TCOL_W  = 6;
    localparam int COLOR_W = 32;
    localparam int PD_W    = 12;
    localparam int TEXEL_W = 12;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 12;
    localparam int H_W     = 16;
    localparam int POS_W   = 24;
    localparam int CFG_IDX_W = 2;

    // divider: dividend wide enough for ((h-rows)*TEX_SIZE << 16) + h
    localparam int DIVD_W    = 40;
    localparam int DEN_W     = DIST_W + 1;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
    localparam int REP_W     = (INTERP > 1) ? $clog2(INTERP) : 1;

    localparam logic [1:0] REGION_CEILING = 2'd0;
    localparam logic [1:0] REGION_WALL    = 2'd1;
    localparam logic [1:0] REGION_FLOOR   = 2'd2;

    localparam logic CMD_COLUMN = 1'b0;
    localparam logic CMD_ROW    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CEILING_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COLOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_DIST     = 2'd2;

    localparam logic [PD_W-1:0] PROJ_DIST_RESET = 12'd256;

    typedef struct packed {
        logic              cmd;
        logic [DIST_W-1:0] ray_depth;
        logic [RAY_W-1:0]  ray_index;
        logic [TCOL_W-1:0] tex_column;
    } t_in_req;

    typedef struct packed {
        logic [1:0]         region;
        logic [COLOR_W-1:0] pixel_color;
        logic [TEXEL_W-1:0] texel_index;
        logic [ROW_W-1:0]   pixel_row;
        logic [COL_W-1:0]   pixel_col;
        logic               last;
    } t_out_rsp;

endpackage

[design/raycast_column_span_generator.sv]
// raycast column span generator top level
// per-column height, texture step and start offset through one shared divider
// depends on rccsg_pkg
module raycast_column_span_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rccsg_pkg::t_in_req                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rccsg_pkg::t_out_rsp               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [rccsg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rccsg_pkg::COLOR_W-1:0]     i_cfg_data
);
    // A new-column request runs up to three restoring divisions of 40 steps
    // each on one shared divider (wall height, texture step, start offset),
    // so the block is busy until they finish and S_FIN stores the column; a zero
    // distance skips the height division and a zero height skips the rest.
    // A row request yields INTERP results, one per cycle while the consumer
    // does not stall, and the next request is taken the cycle after the last
    // one leaves. A row request after the column's last row is accepted and
    // yields nothing. Input stall is high whenever the sequencer is not idle.
    import rccsg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HDIV = 3'd1;
    localparam logic [2:0] S_STEP = 3'd2;
    localparam logic [2:0] S_SDIV = 3'd3;
    localparam logic [2:0] S_PDIV = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [COLOR_W-1:0]   r_ceil_color, n_ceil_color;
    logic [COLOR_W-1:0]   r_floor_color, n_floor_color;
    logic [PD_W-1:0]      r_proj_dist, n_proj_dist;

    logic [ROW_W-1:0]     r_wall_top, n_wall_top;
    logic [ROW_W-1:0]     r_wall_height, n_wall_height;
    logic [POS_W-1:0]     r_tex_step, n_tex_step;
    logic [POS_W-1:0]     r_tex_pos, n_tex_pos;
    logic [ROW_W-1:0]     r_row_count, n_row_count;
    logic [RAY_W-1:0]     r_column_base, n_column_base;
    logic [TCOL_W-1:0]    r_tex_col, n_tex_col;
    logic [H_W-1:0]       r_h, n_h;

    logic [DIVD_W-1:0]    r_dvd, n_dvd;
    logic [DEN_W-1:0]     r_den, n_den;
    logic [DEN_W-1:0]     r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    logic [1:0]           r_region, n_region;
    logic [COLOR_W-1:0]   r_color, n_color;
    logic [TEXEL_W-1:0]   r_texel, n_texel;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [REP_W-1:0]     r_rep, n_rep;

    logic                 in_acc, out_acc, div_ge, rep_last;
    logic [DEN_W:0]       rem_sh, rem_sub;
    logic [ROW_W:0]       wall_end;
    logic [ROW_W-1:0]     trow;
    logic [POS_W:0]       pos_sum;
    logic [ROW_W-1:0]     h_clip;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign rep_last    = (r_rep == REP_W'(INTERP - 1));

    // one restoring division step
    assign rem_sh  = {r_rem, r_dvd[DIVD_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign wall_end = {1'b0, r_wall_top} + {1'b0, r_wall_height};
    assign trow     = (r_tex_pos[POS_W-1:16] >= ROW_W'(TEX_SIZE)) ?
                      ROW_W'(TEX_SIZE - 1) : r_tex_pos[POS_W-1:16];
    assign pos_sum  = {1'b0, r_tex_pos} + {1'b0, r_tex_step};
    assign h_clip   = (r_h >= H_W'(SCREEN_ROWS)) ? ROW_W'(SCREEN_ROWS) : r_h[ROW_W-1:0];

    always_comb begin
        n_state       = r_state;
        n_ceil_color  = r_ceil_color;
        n_floor_color = r_floor_color;
        n_proj_dist   = r_proj_dist;
        n_wall_top    = r_wall_top;
        n_wall_height = r_wall_height;
        n_tex_step    = r_tex_step;
        n_tex_pos     = r_tex_pos;
        n_row_count   = r_row_count;
        n_column_base = r_column_base;
        n_tex_col     = r_tex_col;
        n_h           = r_h;
        n_dvd         = r_dvd;
        n_den         = r_den;
        n_rem         = r_rem;
        n_cnt         = r_cnt;
        n_region      = r_region;
        n_color       = r_color;
        n_texel       = r_texel;
        n_row         = r_row;
        n_rep         = r_rep;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CEILING_COLOR: n_ceil_color  = i_cfg_data;
                CFG_FLOOR_COLOR:   n_floor_color = i_cfg_data;
                CFG_PROJ_DIST:     n_proj_dist   = i_cfg_data[PD_W-1:0];
                default: ;
            endcase
        end

        // divider iterates in any division state while the count runs
        if (r_cnt != '0) begin
            n_rem = div_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            n_dvd = {r_dvd[DIVD_W-2:0], div_ge};
            n_cnt = r_cnt - 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.cmd == CMD_COLUMN) begin
                        n_column_base = i_in_data.ray_index;
                        n_tex_col     = i_in_data.tex_column;
                        if (i_in_data.ray_depth == '0) begin
                            n_h     = '1;
                            n_state = S_STEP;
                        end else begin
                            // h = (2*N*256 + dist) / (2*dist), N = BLOCK_PIXELS*proj_dist
                            n_dvd   = ((DIVD_W'(r_proj_dist) * DIVD_W'(BLOCK_PIXELS)) << 9)
                                      + DIVD_W'(i_in_data.ray_depth);
                            n_den   = {i_in_data.ray_depth, 1'b0};
                            n_rem   = '0;
                            n_cnt   = DIV_CNT_W'(DIVD_W);
                            n_state = S_HDIV;
                        end
                    end else if (r_row_count < ROW_W'(SCREEN_ROWS)) begin
                        n_row   = r_row_count;
                        n_texel = '0;
                        if (r_row_count < r_wall_top) begin
                            n_region = REGION_CEILING;
                            n_color  = r_ceil_color;
                        end else if ({1'b0, r_row_count} < wall_end) begin
                            n_region  = REGION_WALL;
                            n_color   = '0;
                            n_texel   = TEXEL_W'(trow) * TEXEL_W'(TEX_SIZE)
                                        + TEXEL_W'(r_tex_col);
                            n_tex_pos = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
                        end else begin
                            n_region = REGION_FLOOR;
                            n_color  = r_floor_color;
                        end
                        n_rep       = '0;
                        n_row_count = r_row_count + 1'b1;
                        n_state     = S_EMIT;
                    end
                end
            end
            S_HDIV: begin
                if (r_cnt == '0) begin
                    n_h     = (|r_dvd[DIVD_W-1:H_W]) ? '1 : r_dvd[H_W-1:0];
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_h == '0) begin
                    n_tex_step = '0;
                    n_tex_pos  = '0;
                    n_state    = S_FIN;
                end else begin
                    n_dvd   = (DIVD_W'(TEX_SIZE) << 17) + DIVD_W'(r_h);
                    n_den   = DEN_W'({r_h, 1'b0});
                    n_rem   = '0;
                    n_cnt   = DIV_CNT_W'(DIVD_W);
                    n_state = S_SDIV;
                end
            end
            S_SDIV: begin
                if (r_cnt == '0) begin
                    n_tex_step = r_dvd[POS_W-1:0];
                    if (r_h > H_W'(SCREEN_ROWS)) begin
                        // start offset: half the overflow in texture rows
                        n_dvd   = ((DIVD_W'(r_h - H_W'(SCREEN_ROWS)) * DIVD_W'(TEX_SIZE))
                                   << 16) + DIVD_W'(r_h);
                        n_den   = DEN_W'({r_h, 1'b0});
                        n_rem   = '0;
                        n_cnt   = DIV_CNT_W'(DIVD_W);
                        n_state = S_PDIV;
                    end else begin
                        n_tex_pos = '0;
                        n_state   = S_FIN;
                    end
                end
            end
            S_PDIV: begin
                if (r_cnt == '0) begin
                    n_tex_pos = (|r_dvd[DIVD_W-1:POS_W]) ? '1 : r_dvd[POS_W-1:0];
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                n_wall_height = h_clip;
                n_wall_top    = (ROW_W'(SCREEN_ROWS) - h_clip) >> 1;
                n_row_count   = '0;
                n_state       = S_IDLE;
            end
            S_EMIT: begin
                if (out_acc) begin
                    if (rep_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rep = r_rep + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ceil_color  <= '0;
            r_floor_color <= '0;
            r_proj_dist   <= PROJ_DIST_RESET;
            r_wall_top    <= '0;
            r_wall_height <= '0;
            r_tex_step    <= '0;
            r_tex_pos     <= '0;
            r_row_count   <= ROW_W'(SCREEN_ROWS);
            r_column_base <= '0;
            r_tex_col     <= '0;
            r_h           <= '0;
            r_cnt         <= '0;
            r_rep         <= '0;
        end else begin
            r_state       <= n_state;
            r_ceil_color  <= n_ceil_color;
            r_floor_color <= n_floor_color;
            r_proj_dist   <= n_proj_dist;
            r_wall_top    <= n_wall_top;
            r_wall_height <= n_wall_height;
            r_tex_step    <= n_tex_step;
            r_tex_pos     <= n_tex_pos;
            r_row_count   <= n_row_count;
            r_column_base <= n_column_base;
            r_tex_col     <= n_tex_col;
            r_h           <= n_h;
            r_cnt         <= n_cnt;
            r_rep         <= n_rep;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_dvd    <= n_dvd;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_region <= n_region;
        r_color  <= n_color;
        r_texel  <= n_texel;
        r_row    <= n_row;
    end

    always_comb begin
        o_out_data.region      = r_region;
        o_out_data.pixel_color = r_color;
        o_out_data.texel_index = r_texel;
        o_out_data.pixel_row   = r_row;
        o_out_data.pixel_col   = COL_W'(r_column_base) * COL_W'(INTERP) + COL_W'(r_rep);
        o_out_data.last        = (r_row == ROW_W'(SCREEN_ROWS - 1)) && rep_last;
    end

endmodule

[dv/raycast_column_span_generator_test.sv]
// self-checking testbench for raycast_column_span_generator
// predicts the pixel results of every accepted request and checks each result in order
// depends on rccsg_pkg and the raycast_column_span_generator rtl
`timescale 1ns / 1ps

module raycast_column_span_generator_test;
    import rccsg_pkg::*;

    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          SETTLE_CYCLES = 300;
    localparam int          HOLD_CYCLES   = 400;
    localparam logic [63:0] H_SAT         = 64'd65535;
    localparam logic [63:0] POS_MAX       = 64'hFFFFFF;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_req              i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_rsp             o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COLOR_W-1:0]   i_cfg_data  = '0;

    // predictor copy of the registers and column state
    logic [COLOR_W-1:0] ceil_rgb    = '0;
    logic [COLOR_W-1:0] floor_rgb   = '0;
    logic [PD_W-1:0]    pdist       = PROJ_DIST_RESET;
    logic [7:0]         wall_top    = '0;
    logic [7:0]         wall_h      = '0;
    logic [POS_W-1:0]   tex_inc     = '0;
    logic [POS_W-1:0]   tex_acc     = '0;
    logic [7:0]         next_row    = 8'(SCREEN_ROWS);
    logic [RAY_W-1:0]   col_base    = '0;
    logic [TCOL_W-1:0]  tcol_held   = '0;

    t_out_rsp pixel_q[$];
    int       err_count   = 0;
    int       cycle_count = 0;
    int       req_count   = 0;
    int       idle_pct    = 0;
    int       stall_pct   = 0;
    int       hold_len    = 0;

    raycast_column_span_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("raycast_column_span_generator_test: FAIL");
            $finish;
        end
    end

    // long receiver hold-off, counted down here
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            hold_len <= hold_len - 1;
        end
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 100) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic check_pixel(input t_out_rsp got);
        t_out_rsp want;
        if (pixel_q.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel row %0d col %0d",
                                      got.pixel_row, got.pixel_col));
            return;
        end
        want = pixel_q.pop_front();
        if (got.region !== want.region)
            report_mismatch($sformatf("region %0h, want %0h", got.region, want.region));
        if (got.pixel_color !== want.pixel_color)
            report_mismatch($sformatf("pixel_color %0h, want %0h",
                                      got.pixel_color, want.pixel_color));
        if (got.texel_index !== want.texel_index)
            report_mismatch($sformatf("texel_index %0d, want %0d",
                                      got.texel_index, want.texel_index));
        if (got.pixel_row !== want.pixel_row)
            report_mismatch($sformatf("pixel_row %0d, want %0d",
                                      got.pixel_row, want.pixel_row));
        if (got.pixel_col !== want.pixel_col)
            report_mismatch($sformatf("pixel_col %0d, want %0d",
                                      got.pixel_col, want.pixel_col));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid !== 1'b0 && !i_out_stall) begin
            check_pixel(o_out_data);
        end
        i_out_stall <= (hold_len > 0) || ($urandom_range(99) < stall_pct);
    end

    // height, texture step and start offset of a new column
    function automatic void start_column(input t_in_req r);
        logic [63:0] num, depth, h, over, p;
        num   = 64'(BLOCK_PIXELS) * 64'(pdist) * 64'd256;
        depth = 64'(r.ray_depth);
        if (depth == 0) begin
            h = H_SAT;
        end else begin
            h = (2 * num + depth) / (2 * depth);
            if (h > H_SAT) h = H_SAT;
        end
        tex_inc = (h == 0) ? '0 : POS_W'(((64'(TEX_SIZE) << 17) + h) / (2 * h));
        tex_acc = '0;
        if (h > 64'(SCREEN_ROWS)) begin
            over    = h - 64'(SCREEN_ROWS);
            p       = (((over * 64'(TEX_SIZE)) << 16) + h) / (2 * h);
            tex_acc = POS_W'((p > POS_MAX) ? POS_MAX : p);
            h       = 64'(SCREEN_ROWS);
        end
        wall_h    = h[7:0];
        wall_top  = 8'((SCREEN_ROWS - int'(wall_h)) / 2);
        col_base  = r.ray_index;
        tcol_held = r.tex_column;
        next_row  = '0;
    endfunction

    // returns 0 when the request is a row after the column has finished
    function automatic bit predict_pixels(input t_in_req r);
        t_out_rsp     px;
        logic [1:0]   region;
        logic [31:0]  color;
        logic [11:0]  texel;
        logic [31:0]  trow;
        logic [24:0]  acc_sum;
        int           row;
        if (r.cmd == CMD_COLUMN) begin
            start_column(r);
            return 1'b1;
        end
        if (int'(next_row) >= SCREEN_ROWS) return 1'b0;
        row   = int'(next_row);
        texel = '0;
        if (row < int'(wall_top)) begin
            region = REGION_CEILING;
            color  = ceil_rgb;
        end else if (row < int'(wall_top) + int'(wall_h)) begin
            trow = 32'(tex_acc >> 16);
            if (trow >= TEX_SIZE) trow = TEX_SIZE - 1;
            region  = REGION_WALL;
            color   = '0;
            texel   = 12'(trow * TEX_SIZE + 32'(tcol_held));
            acc_sum = {1'b0, tex_acc} + {1'b0, tex_inc};
            tex_acc = (acc_sum > 25'(POS_MAX)) ? POS_W'(POS_MAX) : acc_sum[POS_W-1:0];
        end else begin
            region = REGION_FLOOR;
            color  = floor_rgb;
        end
        for (int k = 0; k < INTERP; k++) begin
            px.region      = region;
            px.pixel_color = color;
            px.texel_index = texel;
            px.pixel_row   = 8'(row);
            px.pixel_col   = 12'(32'(col_base) * INTERP + k);
            px.last        = (row == SCREEN_ROWS - 1) && (k == INTERP - 1);
            pixel_q.push_back(px);
        end
        next_row = 8'(row + 1);
        return 1'b1;
    endfunction

    task automatic send_request(input t_in_req r);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        if (predict_pixels(r)) req_count++;
    endtask

    function automatic t_in_req make_column(input logic [DIST_W-1:0] depth,
                                            input logic [RAY_W-1:0] ray,
                                            input logic [TCOL_W-1:0] tcol);
        t_in_req r;
        r.cmd        = CMD_COLUMN;
        r.ray_depth  = depth;
        r.ray_index  = ray;
        r.tex_column = tcol;
        return r;
    endfunction

    // row requests carry junk in the column fields
    function automatic t_in_req make_row();
        t_in_req r;
        r.cmd        = CMD_ROW;
        r.ray_depth  = DIST_W'($urandom);
        r.ray_index  = RAY_W'($urandom);
        r.tex_column = TCOL_W'($urandom);
        return r;
    endfunction

    // mid_height picks a wall with ceiling, wall and floor rows
    function automatic t_in_req random_column(input bit mid_height);
        logic [DIST_W-1:0] depth;
        int                sh;
        if (mid_height) begin
            depth = DIST_W'((64'(BLOCK_PIXELS) * 64'(pdist) * 64'd256) /
                            64'($urandom_range(20, 180)));
        end else begin
            sh    = $urandom_range(0, DIST_W);
            depth = (sh == 0) ? '0 : DIST_W'($urandom & ((32'd1 << sh) - 1));
        end
        return make_column(depth, RAY_W'($urandom), TCOL_W'($urandom));
    endfunction

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [COLOR_W-1:0] ceil_val,
                                input logic [COLOR_W-1:0] floor_val,
                                input logic [PD_W-1:0] pd_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CEILING_COLOR;
        i_cfg_data  <= ceil_val;
        @(posedge i_clk);
        i_cfg_index <= CFG_FLOOR_COLOR;
        i_cfg_data  <= floor_val;
        @(posedge i_clk);
        i_cfg_index <= CFG_PROJ_DIST;
        i_cfg_data  <= COLOR_W'(pd_val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ceil_rgb  = ceil_val;
        floor_rgb = floor_val;
        pdist     = pd_val;
    endtask

    // rows before any column act on the finished reset state
    task automatic test_rows_after_reset();
        idle_pct  = 0;
        stall_pct = 0;
        send_request(make_row());
        send_request(make_row());
    endtask

    task automatic test_directed_columns();
        // zero distance saturates, clipped to the full screen
        send_request(make_column('0, 10'd1023, 6'd63));
        repeat (3) send_request(make_row());
        // far wall, no wall rows
        send_request(make_column({DIST_W{1'b1}}, '0, '0));
        repeat (2) send_request(make_row());
        send_request(make_column(24'd1, 10'd170, 6'd21));
        send_request(make_row());
        // short wall, restarted before the column is done
        send_request(make_column(24'd419430, 10'd512, 6'd42));
        repeat (3) send_request(make_row());
        // slightly taller than the screen, start offset nonzero
        send_request(make_column(24'd20000, 10'd341, 6'd13));
        repeat (3) send_request(make_row());
    endtask

    task automatic test_backpressure();
        wait_idle();
        idle_pct  = 0;
        stall_pct = 0;
        send_request(random_column(1'b1));
        hold_len <= HOLD_CYCLES;
        repeat (80) send_request(make_row());
        // sender waits for every pending pixel
        wait_idle();
    endtask

    task automatic run_phase(input int idle, input int stall, input bit full_first,
                             input int quota);
        int  start_count;
        int  rows;
        bit  first;
        idle_pct    = idle;
        stall_pct   = stall;
        start_count = req_count;
        first       = 1'b1;
        while (req_count - start_count < quota) begin
            if ((first && full_first) || $urandom_range(99) < 12)
                rows = SCREEN_ROWS + $urandom_range(0, 2);
            else
                rows = $urandom_range(1, 24);
            send_request(random_column(first && full_first || $urandom_range(1)));
            repeat (rows) send_request(make_row());
            first = 1'b0;
        end
    endtask

    task automatic test_random_traffic();
        wait_idle();
        write_config('1, '0, 12'd4095);
        run_phase(0, 0, 1'b0, 80);
        wait_idle();
        write_config(32'($urandom), '1, 12'd1);
        run_phase(73, 0, 1'b1, 80);
        wait_idle();
        write_config(32'($urandom), 32'($urandom), 12'($urandom_range(1, 4095)));
        run_phase(0, 73, 1'b0, 80);
        wait_idle();
        write_config('0, 32'($urandom), PROJ_DIST_RESET);
        run_phase(37, 37, 1'b1, 80);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_rows_after_reset();
        test_directed_columns();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (err_count == 0) begin
            $display("raycast_column_span_generator_test: PASS");
        end else begin
            $display("raycast_column_span_generator_test: FAIL");
        end
        $finish;
    end

endmodule
